@@ src/bcoef_pkg.sv @@
// Shared constants and types for the binomial coefficient block.
package bcoef_pkg;

  localparam int MAX_N     = 62;
  localparam int N_W       = 6;   // width of n and k
  localparam int COEF_W    = 59;  // width of C(n,k)
  localparam int PROD_W    = 64;  // accumulator times factor
  localparam int DIVISOR_W = 5;   // divisor i never exceeds 31
  localparam int DIV_CNT_W = 6;   // one quotient bit per step, PROD_W steps

  typedef struct packed {
    logic                 start;
    logic [PROD_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/bcoef_div.sv @@
// Restoring serial divider: one quotient bit per cycle over a 64-bit dividend.
module bcoef_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bcoef_pkg::div_req_t req,
  output bcoef_pkg::div_rsp_t rsp
);

  logic                                busy_r,    busy_nxt;
  logic                                done_r,    done_nxt;
  logic [bcoef_pkg::DIV_CNT_W-1:0]     cnt_r,     cnt_nxt;
  logic [bcoef_pkg::PROD_W-1:0]        quo_r,     quo_nxt;
  logic [bcoef_pkg::DIVISOR_W-1:0]     rem_r,     rem_nxt;
  logic [bcoef_pkg::DIVISOR_W-1:0]     dvs_r,     dvs_nxt;
  logic [bcoef_pkg::DIVISOR_W:0]       rem_sh;
  logic                                ge;

  // quotient bits shift in at the bottom as dividend bits leave the top
  assign rem_sh = {rem_r, quo_r[bcoef_pkg::PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? bcoef_pkg::DIVISOR_W'(rem_sh - {1'b0, dvs_r})
                   : bcoef_pkg::DIVISOR_W'(rem_sh);
      quo_nxt = {quo_r[bcoef_pkg::PROD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (&cnt_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ src/binomial_coefficient.sv @@
// Binomial coefficient C(n,k): one request in, one exact 59-bit result out. k above n, or n
// above 62, gives 0; k is mirrored to n-k when 2k > n, and k of 0 gives 1. Trivial cases go
// from ST_IDLE through ST_FIN into the output register. Otherwise each of the k-1 rounds
// multiplies the accumulator by n-i+1 and divides exactly by i in a single 64-step serial
// divider, up to 30 rounds at n = 62. The serial divider sets the pace. One request is in
// work at a time; the next is taken as soon as the previous result sits in the output
// register, even before it is collected.
module binomial_coefficient (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bcoef_pkg::N_W-1:0]     in_n_total,
  input  logic [bcoef_pkg::N_W-1:0]     in_k_chosen,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bcoef_pkg::COEF_W-1:0]  out_coefficient
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} state_t;

  state_t                               state_r,   state_nxt;
  logic [bcoef_pkg::N_W-1:0]            n_r,       n_nxt;
  logic [bcoef_pkg::DIVISOR_W-1:0]      kk_r,      kk_nxt;
  logic [bcoef_pkg::N_W-1:0]            i_r,       i_nxt;
  logic [bcoef_pkg::COEF_W-1:0]         acc_r,     acc_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [bcoef_pkg::COEF_W-1:0]         out_coef_r,  out_coef_nxt;

  logic [bcoef_pkg::N_W-1:0]            factor;
  logic [bcoef_pkg::COEF_W+bcoef_pkg::N_W-1:0] prod;
  logic [bcoef_pkg::N_W-1:0]            k_mirror;
  logic                                 mirror;
  bcoef_pkg::div_req_t                  div_req;
  bcoef_pkg::div_rsp_t                  div_rsp;

  bcoef_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign factor   = n_r - i_r + 1'b1;
  assign prod     = acc_r * factor;
  assign mirror   = {in_k_chosen, 1'b0} > {1'b0, in_n_total};
  assign k_mirror = mirror ? in_n_total - in_k_chosen : in_k_chosen;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    kk_nxt        = kk_r;
    i_nxt         = i_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_coef_nxt  = out_coef_r;
    div_req       = '0;
    div_req.dividend = prod[bcoef_pkg::PROD_W-1:0];
    div_req.divisor  = i_r[bcoef_pkg::DIVISOR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt  = in_n_total;
          kk_nxt = k_mirror[bcoef_pkg::DIVISOR_W-1:0];
          i_nxt  = bcoef_pkg::N_W'(2);
          if (in_n_total > bcoef_pkg::N_W'(bcoef_pkg::MAX_N) ||
              in_k_chosen > in_n_total) begin
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else if (k_mirror == '0) begin
            acc_nxt   = bcoef_pkg::COEF_W'(1);
            state_nxt = ST_FIN;
          end else if (k_mirror == bcoef_pkg::N_W'(1)) begin
            acc_nxt   = bcoef_pkg::COEF_W'(in_n_total);
            state_nxt = ST_FIN;
          end else begin
            acc_nxt   = bcoef_pkg::COEF_W'(in_n_total);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          acc_nxt = div_rsp.quotient[bcoef_pkg::COEF_W-1:0];
          if (i_r == {1'b0, kk_r}) begin
            state_nxt = ST_FIN;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    kk_r       <= kk_nxt;
    i_r        <= i_nxt;
    acc_r      <= acc_nxt;
    out_coef_r <= out_coef_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;

  // busy once a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block still ready after accepting a request");

  // divider only started with a divisor in 2..31
  a_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (i_r >= bcoef_pkg::N_W'(2) && i_r <= bcoef_pkg::N_W'(31)))
    else $error("divider started with divisor out of range");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result presented without finishing a computation");

endmodule
